// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the radix map unit.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- src/fdrm_pkg.sv -----
// Package of the radix map unit: transaction structs, codes and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package fdrm_pkg;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_LOOKUP = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
   localparam logic [1:0] STATUS_BAD      = 2'd2;
   localparam logic [1:0] STATUS_FULL     = 2'd3;

   localparam logic [3:0] OP_NOP    = 4'd0;
   localparam logic [3:0] OP_LATCH  = 4'd1;
   localparam logic [3:0] OP_CHECK  = 4'd2;
   localparam logic [3:0] OP_POP    = 4'd3;
   localparam logic [3:0] OP_POPW   = 4'd4;
   localparam logic [3:0] OP_ZERO   = 4'd5;
   localparam logic [3:0] OP_LINK   = 4'd6;
   localparam logic [3:0] OP_LINKW  = 4'd7;
   localparam logic [3:0] OP_RD     = 4'd8;
   localparam logic [3:0] OP_RDW    = 4'd9;
   localparam logic [3:0] OP_INCW   = 4'd10;
   localparam logic [3:0] OP_DEC    = 4'd11;
   localparam logic [3:0] OP_PRUNE  = 4'd12;
   localparam logic [3:0] OP_PRUNEW = 4'd13;
   localparam logic [3:0] OP_DONE   = 4'd14;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] key;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_value;
      logic [10:0] entries;
   } rsp_type;

   typedef struct packed {
      logic [3:0] op;
      logic       alloc_root;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       key_bad;
      logic       value_zero;
      logic       root_present;
      logic       pool_empty;
      logic       leaf;
      logic       top;
      logic       child_none;
      logic       slot_empty;
      logic       cu_zero;
      logic       clr_last;
      logic       rsp_free;
   } stat_type;

endpackage

// ----- src/fdrm_ctrl.sv -----
// Sequencing state machine of the radix map unit.
// Depends on fdrm_pkg for the command and status structs.
`timescale 1ns / 1ps
module fdrm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fdrm_pkg::stat_type stat,
   output fdrm_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_POP    = 4'd2;
   localparam logic [3:0] S_POPW   = 4'd3;
   localparam logic [3:0] S_ZERO   = 4'd4;
   localparam logic [3:0] S_LINK   = 4'd5;
   localparam logic [3:0] S_LINKW  = 4'd6;
   localparam logic [3:0] S_RD     = 4'd7;
   localparam logic [3:0] S_RDW    = 4'd8;
   localparam logic [3:0] S_INCW   = 4'd9;
   localparam logic [3:0] S_DEC    = 4'd10;
   localparam logic [3:0] S_PRUNE  = 4'd11;
   localparam logic [3:0] S_PRUNEW = 4'd12;
   localparam logic [3:0] S_DONE   = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       alloc_root_ff, alloc_root_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      alloc_root_in = alloc_root_ff;
      cmd.op         = fdrm_pkg::OP_NOP;
      cmd.alloc_root = alloc_root_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = fdrm_pkg::OP_LATCH;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.op = fdrm_pkg::OP_CHECK;
            if (stat.action == fdrm_pkg::ACT_CLEAR || stat.key_bad) begin
               state_in = S_DONE;
            end else if (stat.action == fdrm_pkg::ACT_INSERT) begin
               if (stat.value_zero) begin
                  state_in = S_DONE;
               end else if (!stat.root_present) begin
                  alloc_root_in = 1'b1;
                  state_in      = S_POP;
               end else begin
                  state_in = S_RD;
               end
            end else begin
               state_in = stat.root_present ? S_RD : S_DONE;
            end
         end
         S_POP: begin
            cmd.op   = fdrm_pkg::OP_POP;
            state_in = stat.pool_empty ? S_DONE : S_POPW;
         end
         S_POPW: begin
            cmd.op   = fdrm_pkg::OP_POPW;
            state_in = S_ZERO;
         end
         S_ZERO: begin
            cmd.op = fdrm_pkg::OP_ZERO;
            if (stat.clr_last) begin
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            cmd.op   = fdrm_pkg::OP_LINK;
            state_in = alloc_root_ff ? S_RD : S_LINKW;
            alloc_root_in = 1'b0;
         end
         S_LINKW: begin
            cmd.op   = fdrm_pkg::OP_LINKW;
            state_in = S_RD;
         end
         S_RD: begin
            cmd.op   = fdrm_pkg::OP_RD;
            state_in = S_RDW;
         end
         S_RDW: begin
            cmd.op = fdrm_pkg::OP_RDW;
            if (!stat.leaf) begin
               if (!stat.child_none) begin
                  state_in = S_RD;
               end else if (stat.action == fdrm_pkg::ACT_INSERT) begin
                  alloc_root_in = 1'b0;
                  state_in      = S_POP;
               end else begin
                  state_in = S_DONE;
               end
            end else if (stat.action == fdrm_pkg::ACT_INSERT) begin
               state_in = stat.slot_empty ? S_INCW : S_DONE;
            end else if (stat.action == fdrm_pkg::ACT_REMOVE) begin
               state_in = stat.slot_empty ? S_DONE : S_DEC;
            end else begin
               state_in = S_DONE;
            end
         end
         S_INCW: begin
            cmd.op   = fdrm_pkg::OP_INCW;
            state_in = S_DONE;
         end
         S_DEC: begin
            cmd.op   = fdrm_pkg::OP_DEC;
            state_in = S_PRUNE;
         end
         S_PRUNE: begin
            cmd.op   = fdrm_pkg::OP_PRUNE;
            state_in = (stat.top || !stat.cu_zero) ? S_DONE : S_PRUNEW;
         end
         S_PRUNEW: begin
            cmd.op   = fdrm_pkg::OP_PRUNEW;
            state_in = S_PRUNE;
         end
         S_DONE: begin
            cmd.op = fdrm_pkg::OP_DONE;
            if (stat.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         alloc_root_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         alloc_root_ff <= alloc_root_in;
      end
   end

endmodule

// ----- src/fdrm_datapath.sv -----
// Datapath of the radix map unit: slot, count and free-stack memories,
// walk registers and the result register. Depends on fdrm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fdrm_datapath #(
   parameter int LEVELS     = 4,
   parameter int SLOT_BITS  = 4,
   parameter int NODES      = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  fdrm_pkg::cmd_type  cmd,
   output fdrm_pkg::stat_type stat,
   input  fdrm_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output fdrm_pkg::rsp_type  rsp_data
);

   localparam int NB       = $clog2(NODES);
   localparam int FCW      = $clog2(NODES + 1);
   localparam int LVW      = $clog2(LEVELS);
   localparam int FAN      = 1 << SLOT_BITS;
   localparam int SW       = (VALUE_BITS > FCW) ? VALUE_BITS : FCW;
   localparam int VW       = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int KEY_BITS = LEVELS * SLOT_BITS;
   localparam int AW       = NB + SLOT_BITS;
   localparam int UW       = SLOT_BITS + 1;

   logic [SW-1:0] slot_mem [NODES*FAN];
   logic [UW-1:0] used_mem [NODES];
   logic [NB-1:0] stk_mem  [NODES];

   logic          slot_we, used_we, stk_we;
   logic [AW-1:0] slot_wa, slot_ra;
   logic [SW-1:0] slot_wd, slot_q;
   logic [NB-1:0] used_wa, used_ra, stk_wa, stk_ra, stk_q;
   logic [UW-1:0] used_wd, used_q;
   logic [NB-1:0] stk_wd;

   logic [1:0]    action_ff, action_in;
   logic [63:0]   key_ff, key_in;
   logic [31:0]   value_ff, value_in;
   logic [NB-1:0] n_ff, n_in, newn_ff, newn_in, cur_ff, cur_in, root_ff, root_in;
   logic [LVW-1:0] lvl_ff, lvl_in;
   logic [SLOT_BITS-1:0] clr_ff, clr_in;
   logic [UW-1:0] cu_ff, cu_in;
   logic          idsel_ff, idsel_in;
   logic [1:0]    status_ff, status_in;
   logic [31:0]   found_ff, found_in;
   logic [FCW-1:0] fc_ff, fc_in, lw_ff, lw_in, fc_dec;
   logic          root_present_ff, root_present_in;
   logic [10:0]   entry_ff, entry_in;
   logic          rsp_valid_ff, rsp_valid_in;
   fdrm_pkg::rsp_type rsp_ff, rsp_in;
   logic [NB-1:0] path_ff [LEVELS];
   logic          path_we;

   logic [SLOT_BITS-1:0] sel_slot, up_slot;
   logic [NB-1:0] par_node, child;
   logic [SW-1:0] val_w;
   logic          top, leaf, child_none, slot_empty;

   assign sel_slot   = key_ff[int'(lvl_ff) * SLOT_BITS +: SLOT_BITS];
   assign up_slot    = key_ff[(int'(lvl_ff) + 1) * SLOT_BITS +: SLOT_BITS];
   assign par_node   = path_ff[lvl_ff + LVW'(1)];
   assign val_w      = SW'(value_ff[VW-1:0]);
   assign top        = (lvl_ff == LVW'(LEVELS - 1));
   assign leaf       = (lvl_ff == '0);
   assign slot_empty = (slot_q == '0);
   assign child_none = slot_empty || (slot_q > SW'(NODES));
   assign child      = NB'(slot_q - SW'(1));
   assign fc_dec     = fc_ff - FCW'(1);

   assign stat.action       = action_ff;
   assign stat.key_bad      = ((key_ff >> KEY_BITS) != '0);
   assign stat.value_zero   = (value_ff[VW-1:0] == '0);
   assign stat.root_present = root_present_ff;
   assign stat.pool_empty   = (fc_ff == '0);
   assign stat.leaf         = leaf;
   assign stat.top          = top;
   assign stat.child_none   = child_none;
   assign stat.slot_empty   = slot_empty;
   assign stat.cu_zero      = (cu_ff == '0);
   assign stat.clr_last     = (clr_ff == SLOT_BITS'(FAN - 1));
   assign stat.rsp_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      action_in       = action_ff;
      key_in          = key_ff;
      value_in        = value_ff;
      n_in            = n_ff;
      newn_in         = newn_ff;
      cur_in          = cur_ff;
      root_in         = root_ff;
      lvl_in          = lvl_ff;
      clr_in          = clr_ff;
      cu_in           = cu_ff;
      idsel_in        = idsel_ff;
      status_in       = status_ff;
      found_in        = found_ff;
      fc_in           = fc_ff;
      lw_in           = lw_ff;
      root_present_in = root_present_ff;
      entry_in        = entry_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      path_we         = 1'b0;
      slot_we         = 1'b0;
      slot_wa         = {n_ff, sel_slot};
      slot_ra         = {n_ff, sel_slot};
      slot_wd         = '0;
      used_we         = 1'b0;
      used_wa         = n_ff;
      used_ra         = n_ff;
      used_wd         = used_q + UW'(1);
      stk_we          = 1'b0;
      stk_wa          = fc_ff[NB-1:0];
      stk_wd          = cur_ff;
      stk_ra          = fc_dec[NB-1:0];
      unique case (cmd.op)
         fdrm_pkg::OP_LATCH: begin
            action_in = req_data.action;
            key_in    = req_data.key;
            value_in  = req_data.value;
         end
         fdrm_pkg::OP_CHECK: begin
            n_in      = root_ff;
            lvl_in    = LVW'(LEVELS - 1);
            found_in  = '0;
            status_in = fdrm_pkg::STATUS_OK;
            if (action_ff == fdrm_pkg::ACT_CLEAR) begin
               fc_in           = FCW'(NODES);
               lw_in           = FCW'(NODES);
               root_present_in = 1'b0;
               root_in         = '0;
               entry_in        = '0;
            end else if (stat.key_bad ||
                         (action_ff == fdrm_pkg::ACT_INSERT && stat.value_zero)) begin
               status_in = fdrm_pkg::STATUS_BAD;
            end else if (action_ff != fdrm_pkg::ACT_INSERT && !root_present_ff) begin
               status_in = fdrm_pkg::STATUS_NOTFOUND;
            end
         end
         fdrm_pkg::OP_POP: begin
            if (fc_ff == '0) begin
               status_in = fdrm_pkg::STATUS_FULL;
            end else begin
               fc_in    = fc_dec;
               idsel_in = (fc_dec < lw_ff);
               if (fc_dec < lw_ff) begin
                  lw_in = fc_dec;
               end
            end
         end
         fdrm_pkg::OP_POPW: begin
            newn_in = idsel_ff ? fc_ff[NB-1:0] : stk_q;
            clr_in  = '0;
         end
         fdrm_pkg::OP_ZERO: begin
            slot_we = 1'b1;
            slot_wa = {newn_ff, clr_ff};
            if (clr_ff == '0) begin
               used_we = 1'b1;
               used_wa = newn_ff;
               used_wd = '0;
            end
            clr_in = clr_ff + SLOT_BITS'(1);
         end
         fdrm_pkg::OP_LINK: begin
            if (cmd.alloc_root) begin
               root_in         = newn_ff;
               root_present_in = 1'b1;
               n_in            = newn_ff;
               lvl_in          = LVW'(LEVELS - 1);
            end else begin
               slot_we = 1'b1;
               slot_wd = SW'(newn_ff) + SW'(1);
            end
         end
         fdrm_pkg::OP_LINKW: begin
            used_we = 1'b1;
            n_in    = newn_ff;
            lvl_in  = lvl_ff - LVW'(1);
         end
         fdrm_pkg::OP_RDW: begin
            if (!leaf) begin
               path_we = 1'b1;
               if (!child_none) begin
                  n_in   = child;
                  lvl_in = lvl_ff - LVW'(1);
               end else if (action_ff != fdrm_pkg::ACT_INSERT) begin
                  status_in = fdrm_pkg::STATUS_NOTFOUND;
               end
            end else begin
               case (action_ff)
                  fdrm_pkg::ACT_INSERT: begin
                     slot_we = 1'b1;
                     slot_wd = val_w;
                     if (slot_empty) begin
                        entry_in = entry_ff + 11'd1;
                     end
                  end
                  fdrm_pkg::ACT_REMOVE: begin
                     if (slot_empty) begin
                        status_in = fdrm_pkg::STATUS_NOTFOUND;
                     end else begin
                        found_in = 32'(slot_q);
                        slot_we  = 1'b1;
                        entry_in = entry_ff - 11'd1;
                        cur_in   = n_ff;
                     end
                  end
                  default: begin
                     found_in  = 32'(slot_q);
                     status_in = slot_empty ? fdrm_pkg::STATUS_NOTFOUND
                                            : fdrm_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         fdrm_pkg::OP_INCW: begin
            used_we = 1'b1;
         end
         fdrm_pkg::OP_DEC: begin
            used_we = 1'b1;
            used_wd = used_q - UW'(1);
            cu_in   = used_q - UW'(1);
         end
         fdrm_pkg::OP_PRUNE: begin
            if (top) begin
               if (cu_ff == '0) begin
                  stk_we          = 1'b1;
                  stk_wd          = root_ff;
                  fc_in           = fc_ff + FCW'(1);
                  root_present_in = 1'b0;
                  root_in         = '0;
               end
            end else if (cu_ff == '0) begin
               slot_we = 1'b1;
               slot_wa = {par_node, up_slot};
               used_ra = par_node;
               stk_we  = 1'b1;
               fc_in   = fc_ff + FCW'(1);
               cur_in  = par_node;
            end
         end
         fdrm_pkg::OP_PRUNEW: begin
            used_we = 1'b1;
            used_wa = cur_ff;
            used_wd = used_q - UW'(1);
            cu_in   = used_q - UW'(1);
            lvl_in  = lvl_ff + LVW'(1);
         end
         fdrm_pkg::OP_DONE: begin
            if (stat.rsp_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = status_ff;
               rsp_in.found_value = found_ff;
               rsp_in.entries     = entry_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_wa] <= slot_wd;
      end
      slot_q <= slot_mem[slot_ra];
   end

   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_wa] <= used_wd;
      end
      used_q <= used_mem[used_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      stk_q <= stk_mem[stk_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff           <= FCW'(NODES);
         lw_ff           <= FCW'(NODES);
         root_present_ff <= 1'b0;
         root_ff         <= '0;
         entry_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         fc_ff           <= fc_in;
         lw_ff           <= lw_in;
         root_present_ff <= root_present_in;
         root_ff         <= root_in;
         entry_ff        <= entry_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      key_ff    <= key_in;
      value_ff  <= value_in;
      n_ff      <= n_in;
      newn_ff   <= newn_in;
      cur_ff    <= cur_in;
      lvl_ff    <= lvl_in;
      clr_ff    <= clr_in;
      cu_ff     <= cu_in;
      idsel_ff  <= idsel_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      rsp_ff    <= rsp_in;
      if (path_we) begin
         path_ff[lvl_ff] <= n_ff;
      end
   end

   `ASSERT_ALWAYS(a_fc_range, clock, reset, fc_ff <= FCW'(NODES), "free count above pool size")
   `ASSERT_ALWAYS(a_low_mark, clock, reset, lw_ff <= fc_ff, "low mark above free count")
   `ASSERT_IMPLIES(a_root_idle, clock, reset, !root_present_ff, root_ff == '0, "stale root index")

endmodule

// ----- src/fixed_depth_radix_map_unit.sv -----
// Top level of the fixed-depth radix map unit.
// Depends on fdrm_pkg, fdrm_ctrl and fdrm_datapath.
//
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   fdrm_pkg::req_type (action, key, value)
// rsp_      out        rsp_valid/rsp_ready   fdrm_pkg::rsp_type (status, found_value, entries)
//
// One transaction at a time. A lookup walks down from the root, reading one slot per level;
// a clear or a rejected request goes straight to the result. A remove also clears the slot,
// decrements the leaf's use count and frees emptied nodes upward, the root included. An
// insert zeroes all 2^SLOT_BITS slots of each node it allocates, links it into its parent
// (the root into the root register) and raises the leaf's use count if it fills an empty slot.
// Reset restores the full free pool and an empty map; memories need no sweep.
// A result waits in the output register while the next request is taken; the next result
// stalls until that register is read.
`timescale 1ns / 1ps
module fixed_depth_radix_map_unit #(
   parameter int LEVELS     = 4,
   parameter int SLOT_BITS  = 4,
   parameter int NODES      = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fdrm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fdrm_pkg::rsp_type rsp_data
);

   fdrm_pkg::cmd_type  cmd;
   fdrm_pkg::stat_type stat;

   fdrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fdrm_datapath #(
      .LEVELS     (LEVELS),
      .SLOT_BITS  (SLOT_BITS),
      .NODES      (NODES),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
